// ----- design/lhb_pkg.sv -----
// lhb_pkg: shared types and constants for the latency histogram binner
// item, result and queue entry structs, state machine enums, register codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lhb_pkg;

    localparam int BIN_COUNT_DEF  = 4096;
    localparam int VALUE_BITS_DEF = 32;

    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 64;
    localparam int COUNT_W    = 32;
    localparam int BIN_W      = 12;
    localparam int BIN_IDX_W  = 16;
    localparam int DIV_STEP_W = $clog2(SAMPLE_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd2;

    localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST  = 32'd0;
    localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST = 32'hFFFF_FFFF;
    localparam logic [SAMPLE_W-1:0] BIN_WIDTH_RST  = 32'd100;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        KIND_ADD  = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [SAMPLE_W-1:0]  sample_value;
        logic [BIN_W-1:0]     bin_select;
    } item_t;

    typedef struct packed {
        logic [BIN_W-1:0]     bin_index;
        logic [COUNT_W-1:0]   bin_count;
        logic                 out_of_range;
        logic [COUNT_W-1:0]   max_count;
        logic [SAMPLE_W-1:0]  min_seen;
        logic [SAMPLE_W-1:0]  max_seen;
        logic [COUNT_W-1:0]   total_count;
        logic [SUM_W-1:0]     total_sum;
        logic [BIN_W-1:0]     lowest_bin;
        logic [BIN_W-1:0]     highest_bin;
    } result_t;

    // classified item handed from the front to the back
    typedef struct packed {
        kind_t                kind;
        logic                 flag;
        logic                 miss;
        logic [BIN_IDX_W-1:0] bin;
        logic [SAMPLE_W-1:0]  sample;
    } op_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_DONE,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_CALC
    } back_state_t;

endpackage

`default_nettype wire

// ----- design/latency_histogram_binner_top.sv -----
// latency_histogram_binner_top: fixed-width latency histogram with statistics
// depends on lhb_pkg, lhb_front, lhb_queue, lhb_back, lhb_ram
//
//   channel   handshake                  payload     role
//   cfg       cfg_wr_en                  cfg_index,  register write, no wait
//                                        cfg_data
//   item      item_valid / item_ready    item        add sample or read bin
//   result    result_valid / result_ready result     one result per item
//
// an add item inside the range holds the front while the bin divider runs:
// a restoring divider makes one quotient bit a cycle
// reads and out-of-range samples skip the divider; the front takes the next
// item only after it has pushed the last one into the queue
// after reset the back sweeps the bin store with item_ready low; config
// writes are taken throughout
// a two-entry queue parts front and back, a result register parts the back
// from the output, so the front keeps dividing while a result waits
`timescale 1ns / 1ps
`default_nettype none

module latency_histogram_binner_top
    import lhb_pkg::*;
#(
    parameter int BIN_COUNT  = BIN_COUNT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_t                    result
);

    logic clearing;
    logic front_valid, front_ready;
    op_t  front_op;
    logic back_valid, back_ready;
    op_t  back_op;

    lhb_front #(
        .BIN_COUNT  (BIN_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .hold       (clearing),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .op_valid   (front_valid),
        .op_ready   (front_ready),
        .op         (front_op)
    );

    lhb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_op)
    );

    lhb_back #(
        .BIN_COUNT (BIN_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .clearing     (clearing),
        .op_valid     (back_valid),
        .op_ready     (back_ready),
        .op           (back_op),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- design/lhb_ram.sv -----
// lhb_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lhb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/lhb_front.sv -----
// lhb_front: config registers, item intake, range check and bin divider
// depends on lhb_pkg
`timescale 1ns / 1ps
`default_nettype none

module lhb_front
    import lhb_pkg::*;
#(
    parameter int BIN_COUNT  = BIN_COUNT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  hold,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire item_t                 item,
    output logic                       op_valid,
    input  wire logic                  op_ready,
    output op_t                        op
);

    localparam int SAMPLE_BITS = (VALUE_BITS < SAMPLE_W) ? VALUE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        {SAMPLE_W{1'b1}} >> (SAMPLE_W - SAMPLE_BITS);
    localparam logic [SAMPLE_W-1:0]    LAST_BIN_Q  = SAMPLE_W'(BIN_COUNT - 1);
    localparam logic [BIN_IDX_W-1:0]   LAST_BIN    = BIN_IDX_W'(BIN_COUNT - 1);
    localparam logic [BIN_IDX_W:0]     BIN_LIMIT   = (BIN_IDX_W + 1)'(BIN_COUNT);
    localparam logic [DIV_STEP_W-1:0]  LAST_STEP   = DIV_STEP_W'(SAMPLE_W - 1);

    front_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0]   range_low_reg, range_high_reg, bin_width_reg;
    op_t                   op_reg, op_next;
    logic [SAMPLE_W-1:0]   rem_reg, rem_next;
    logic [SAMPLE_W-1:0]   quo_reg, quo_next;
    logic [SAMPLE_W-1:0]   div_reg, div_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;

    logic [SAMPLE_W-1:0]   sample;
    logic                  outside;
    logic                  accept;
    logic [SAMPLE_W:0]     shifted;
    logic [SAMPLE_W:0]     trial;

    assign sample  = item.sample_value & SAMPLE_MASK;
    assign outside = (sample < range_low_reg) || (sample > range_high_reg);
    assign accept  = item_valid && item_ready;

    // restoring divider, one quotient bit a cycle
    assign shifted = {rem_reg, quo_reg[SAMPLE_W-1]};
    assign trial   = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RANGE_LOW_RST;
            range_high_reg <= RANGE_HIGH_RST;
            bin_width_reg  <= BIN_WIDTH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_RANGE_LOW:  range_low_reg  <= cfg_data;
                CFG_RANGE_HIGH: range_high_reg <= cfg_data;
                CFG_BIN_WIDTH:  bin_width_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (item.kind == KIND_READ || outside)
                    begin
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = F_DONE;
                end
            end
            F_DONE:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (op_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        op_valid   = 1'b0;
        unique case (state_reg)
            F_IDLE:  item_ready = !hold;
            F_PUSH:  op_valid   = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        op_next   = op_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        step_next = step_reg;
        if (state_reg == F_IDLE && accept)
        begin
            op_next.kind   = item.kind;
            op_next.sample = sample;
            op_next.flag   = 1'b0;
            op_next.miss   = 1'b0;
            op_next.bin    = '0;
            if (item.kind == KIND_READ)
            begin
                op_next.bin  = BIN_IDX_W'(item.bin_select);
                op_next.miss = (BIN_IDX_W + 1)'(item.bin_select) >= BIN_LIMIT;
            end
            else if (outside)
            begin
                op_next.flag = 1'b1;
            end
            rem_next  = '0;
            quo_next  = sample - range_low_reg;
            div_next  = (bin_width_reg == '0) ? SAMPLE_W'(1) : bin_width_reg;
            step_next = '0;
        end
        else if (state_reg == F_DIV)
        begin
            if (!trial[SAMPLE_W])
            begin
                rem_next = trial[SAMPLE_W-1:0];
                quo_next = {quo_reg[SAMPLE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[SAMPLE_W-1:0];
                quo_next = {quo_reg[SAMPLE_W-2:0], 1'b0};
            end
            step_next = step_reg + DIV_STEP_W'(1);
        end
        else if (state_reg == F_DONE)
        begin
            if (quo_reg > LAST_BIN_Q)
            begin
                op_next.bin  = LAST_BIN;
                op_next.flag = 1'b1;
            end
            else
            begin
                op_next.bin = quo_reg[BIN_IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign op = op_reg;

`ifndef SYNTHESIS
    a_add_bin_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && op.kind == KIND_ADD) |-> (op.bin <= LAST_BIN))
        else $error("add item leaves front with bin past the store");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_DIV) |-> (div_reg != '0))
        else $error("divider running with zero divisor");
`endif

endmodule

`default_nettype wire

// ----- design/lhb_queue.sv -----
// lhb_queue: short fifo of classified items between front and back
// depends on lhb_pkg
`timescale 1ns / 1ps
`default_nettype none

module lhb_queue
    import lhb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire op_t  push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output op_t       pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire, pop_fire;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/lhb_back.sv -----
// lhb_back: bin store clearing, count update, statistics and result register
// depends on lhb_pkg and lhb_ram
`timescale 1ns / 1ps
`default_nettype none

module lhb_back
    import lhb_pkg::*;
#(
    parameter int BIN_COUNT = BIN_COUNT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    output logic      clearing,
    input  wire logic op_valid,
    output logic      op_ready,
    input  wire op_t  op,
    output logic      result_valid,
    input  wire logic result_ready,
    output result_t   result
);

    localparam int ADDR_W = $clog2(BIN_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BIN_COUNT - 1);

    back_state_t state_reg, state_next;

    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    op_t                  op_reg;
    logic [SAMPLE_W-1:0]  min_reg, min_next;
    logic [SAMPLE_W-1:0]  max_reg, max_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [COUNT_W-1:0]   peak_reg, peak_next;
    logic [BIN_IDX_W-1:0] first_reg, first_next;
    logic [BIN_IDX_W-1:0] last_reg, last_next;
    logic                 result_valid_reg, result_valid_next;
    result_t              result_reg, result_next;

    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [COUNT_W-1:0]   ram_wr_data;
    logic                 ram_rd_en;
    logic [COUNT_W-1:0]   ram_rd_data;

    logic                 out_free;
    logic                 fire;
    logic                 is_add;
    logic [COUNT_W-1:0]   cur_count;
    logic [COUNT_W-1:0]   new_count;
    logic [SUM_W:0]       sum_wide;

    lhb_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BIN_COUNT)
    ) u_bin_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (op.bin[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign out_free  = !result_valid_reg || result_ready;
    assign fire      = (state_reg == B_CALC) && out_free;
    assign is_add    = (op_reg.kind == KIND_ADD);
    assign cur_count = op_reg.miss ? '0 : ram_rd_data;
    assign new_count = (cur_count == '1) ? cur_count : cur_count + COUNT_W'(1);
    assign sum_wide  = {1'b0, sum_reg} + (SUM_W + 1)'(op_reg.sample);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (op_valid)
                begin
                    state_next = B_CALC;
                end
            end
            B_CALC:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clearing    = 1'b0;
        op_ready    = 1'b0;
        ram_rd_en   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = op_reg.bin[ADDR_W-1:0];
        ram_wr_data = new_count;
        unique case (state_reg)
            B_CLEAR:
            begin
                clearing    = 1'b1;
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = '0;
            end
            B_IDLE:
            begin
                op_ready  = 1'b1;
                ram_rd_en = op_valid;
            end
            B_CALC:
            begin
                ram_wr_en = out_free && is_add;
            end
            default: ;
        endcase
    end

    // statistics and result for the item in calc
    always_comb
    begin
        min_next          = min_reg;
        max_next          = max_reg;
        total_next        = total_reg;
        sum_next          = sum_reg;
        peak_next         = peak_reg;
        first_next        = first_reg;
        last_next         = last_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        if (fire)
        begin
            if (is_add)
            begin
                if (total_reg == '0 || op_reg.sample > max_reg)
                begin
                    max_next = op_reg.sample;
                end
                if (total_reg == '0 || op_reg.sample < min_reg)
                begin
                    min_next = op_reg.sample;
                end
                if (peak_reg == '0)
                begin
                    first_next = op_reg.bin;
                    last_next  = op_reg.bin;
                end
                else
                begin
                    if (op_reg.bin < first_reg)
                    begin
                        first_next = op_reg.bin;
                    end
                    if (op_reg.bin > last_reg)
                    begin
                        last_next = op_reg.bin;
                    end
                end
                if (new_count > peak_reg)
                begin
                    peak_next = new_count;
                end
                sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                if (total_reg != '1)
                begin
                    total_next = total_reg + COUNT_W'(1);
                end
            end
            result_valid_next        = 1'b1;
            result_next.bin_index    = op_reg.bin[BIN_W-1:0];
            result_next.bin_count    = is_add ? new_count : cur_count;
            result_next.out_of_range = is_add && op_reg.flag;
            result_next.max_count    = peak_next;
            result_next.min_seen     = min_next;
            result_next.max_seen     = max_next;
            result_next.total_count  = total_next;
            result_next.total_sum    = sum_next;
            result_next.lowest_bin   = first_next[BIN_W-1:0];
            result_next.highest_bin  = last_next[BIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_CLEAR;
            clr_addr_reg     <= '0;
            min_reg          <= '0;
            max_reg          <= '0;
            total_reg        <= '0;
            sum_reg          <= '0;
            peak_reg         <= '0;
            first_reg        <= '0;
            last_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            min_reg          <= min_next;
            max_reg          <= max_next;
            total_reg        <= total_next;
            sum_reg          <= sum_next;
            peak_reg         <= peak_next;
            first_reg        <= first_next;
            last_reg         <= last_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (op_valid && op_ready)
        begin
            op_reg <= op;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_min_not_above_max: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != '0) |-> (min_reg <= max_reg))
        else $error("smallest sample above largest sample");

    a_occupied_bins: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != '0) |-> (peak_reg != '0 && first_reg <= last_reg))
        else $error("occupied bin tracking inconsistent with sample count");

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> (!op_ready && !result_valid_reg))
        else $error("item taken or result shown during bin store clearing");
`endif

endmodule

`default_nettype wire
